// ===== rtl/retry_backoff_scheduler_top_assert.svh =====
// Assertion macros shared by the retry backoff scheduler modules.
`ifndef RETRY_BACKOFF_SCHEDULER_TOP_ASSERT_SVH
`define RETRY_BACKOFF_SCHEDULER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RBS_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("rbs same-cycle check failed");

// next-cycle implication, checked outside reset
`define RBS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rbs next-cycle check failed");

`endif

// ===== rtl/rbs_pkg.sv =====
// Types, constants and codes for the retry backoff scheduler.
package rbs_pkg;

  localparam int REG_COUNT             = 6;
  localparam int SLOT_W                = 16;
  localparam int SLOT_IDX_W            = 3;
  localparam int ADDR_W                = 5;
  localparam int DATA_W                = 32;
  localparam int CNT_W                 = 8;
  localparam int RND_W                 = 32;
  localparam int TMO_W                 = 7;
  localparam int BIT_CNT_W             = 5;
  localparam int DEFAULT_TABLE_ENTRIES = 6;
  localparam int MS_PER_S              = 1000;
  localparam int TMO_SHIFT             = 26;
  localparam int TMO_MULT_W            = 17;
  localparam int TMO_MULT              = ((2 ** TMO_SHIFT) + MS_PER_S - 1) / MS_PER_S;

  typedef logic [REG_COUNT-1:0][SLOT_W-1:0] slot_table_t;

  localparam slot_table_t SLOT_RESET = {
    16'd64000, 16'd32000, 16'd16000, 16'd8000, 16'd4000, 16'd2000
  };

  typedef struct packed {
    logic             is_refresh_action;
    logic             is_retry_attempt;
    logic [RND_W-1:0] random_word;
  } req_t;

  typedef struct packed {
    logic              scheduled;
    logic              select_next_server;
    logic [SLOT_W-1:0] delay_ms;
    logic [TMO_W-1:0]  timeout_s;
    logic [CNT_W-1:0]  attempt_number;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_DIVIDE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic last_bit;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/rbs_regs.sv =====
// APB register file holding the retry timeout table.
module rbs_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rbs_pkg::ADDR_W-1:0]    paddr,
  input  logic [rbs_pkg::DATA_W-1:0]    pwdata,
  output logic [rbs_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output rbs_pkg::slot_table_t          slots
);

  logic [rbs_pkg::SLOT_IDX_W-1:0] idx;
  logic                           idx_ok;
  logic                           wr;

  assign idx    = paddr[rbs_pkg::ADDR_W-1:2];
  assign idx_ok = idx < rbs_pkg::SLOT_IDX_W'(rbs_pkg::REG_COUNT);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots <= rbs_pkg::SLOT_RESET;
    end else if (wr && idx_ok) begin
      slots[idx] <= pwdata[rbs_pkg::SLOT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (idx_ok) begin
      prdata = {{(rbs_pkg::DATA_W-rbs_pkg::SLOT_W){1'b0}}, slots[idx]};
    end
  end

endmodule

// ===== rtl/rbs_ctrl.sv =====
// Control state machine sequencing lookup, remainder steps and result load.
module rbs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rbs_pkg::status_t status,
  output rbs_pkg::cmd_t    cmd
);

  `include "retry_backoff_scheduler_top_assert.svh"

  rbs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rbs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rbs_pkg::ST_IDLE: begin
        if (in_valid) state_next = rbs_pkg::ST_LOOKUP;
      end
      rbs_pkg::ST_LOOKUP: begin
        state_next = status.skip ? rbs_pkg::ST_DONE : rbs_pkg::ST_DIVIDE;
      end
      rbs_pkg::ST_DIVIDE: begin
        if (status.last_bit) state_next = rbs_pkg::ST_DONE;
      end
      rbs_pkg::ST_DONE: begin
        if (status.out_free) state_next = rbs_pkg::ST_IDLE;
      end
      default: state_next = rbs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      rbs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      rbs_pkg::ST_LOOKUP: cmd.start  = 1'b1;
      rbs_pkg::ST_DIVIDE: cmd.step   = 1'b1;
      rbs_pkg::ST_DONE:   cmd.finish = status.out_free;
      default: cmd = '0;
    endcase
  end

  `RBS_ASSERT_NEXT(a_load_to_lookup, cmd.load, state == rbs_pkg::ST_LOOKUP)
  `RBS_ASSERT_NEXT(a_div_end, cmd.step && status.last_bit, state == rbs_pkg::ST_DONE)

endmodule

// ===== rtl/rbs_dp.sv =====
// Datapath: retry counters, table lookup, bit-serial remainder and result word.
module rbs_dp #(
  parameter int TABLE_ENTRIES = rbs_pkg::DEFAULT_TABLE_ENTRIES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rbs_pkg::slot_table_t slots,
  input  rbs_pkg::req_t        in_data,
  input  rbs_pkg::cmd_t        cmd,
  output rbs_pkg::status_t     status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rbs_pkg::rsp_t        out_data
);

  `include "retry_backoff_scheduler_top_assert.svh"

  localparam int PROD_W = rbs_pkg::SLOT_W + rbs_pkg::TMO_MULT_W;
  localparam logic [rbs_pkg::TMO_MULT_W-1:0] TmoMult =
    rbs_pkg::TMO_MULT_W'(rbs_pkg::TMO_MULT);

  logic [rbs_pkg::CNT_W-1:0]     refresh_ctr;
  logic [rbs_pkg::CNT_W-1:0]     general_ctr;
  logic [rbs_pkg::CNT_W-1:0]     count;
  logic [rbs_pkg::SLOT_W-1:0]    entry;
  logic [rbs_pkg::RND_W-1:0]     rnd;
  logic [rbs_pkg::SLOT_W-1:0]    rem;
  logic [rbs_pkg::BIT_CNT_W-1:0] bit_cnt;
  logic [rbs_pkg::TMO_W-1:0]     tmo;

  logic [rbs_pkg::CNT_W-1:0]     sel_ctr;
  logic [rbs_pkg::CNT_W-1:0]     count_next;
  logic                          in_range;
  logic [rbs_pkg::SLOT_W-1:0]    entry_next;
  logic [rbs_pkg::SLOT_W-1:0]    half;
  logic [rbs_pkg::SLOT_W-1:0]    trial;
  logic [PROD_W-1:0]             prod;
  logic                          out_free;

  assign sel_ctr    = in_data.is_refresh_action ? refresh_ctr : general_ctr;
  assign count_next = in_data.is_retry_attempt ? sel_ctr + 1'b1 : '0;
  assign in_range   = (count_next < rbs_pkg::CNT_W'(TABLE_ENTRIES)) &&
                      (count_next < rbs_pkg::CNT_W'(rbs_pkg::REG_COUNT));
  assign entry_next = in_range ? slots[count_next[rbs_pkg::SLOT_IDX_W-1:0]] : '0;

  assign half  = {1'b0, entry[rbs_pkg::SLOT_W-1:1]};
  assign trial = {rem[rbs_pkg::SLOT_W-2:0], rnd[rbs_pkg::RND_W-1]};
  assign prod  = {{rbs_pkg::TMO_MULT_W{1'b0}}, entry} * TmoMult;

  assign out_free        = !out_valid || out_ready;
  assign status.skip     = (half == '0);
  assign status.last_bit = (bit_cnt == '1);
  assign status.out_free = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_ctr <= '0;
      general_ctr <= '0;
    end else if (cmd.load) begin
      if (in_data.is_refresh_action) begin
        refresh_ctr <= count_next;
      end else begin
        general_ctr <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      count <= count_next;
      entry <= entry_next;
      rnd   <= in_data.random_word;
    end else if (cmd.step) begin
      rnd <= {rnd[rbs_pkg::RND_W-2:0], 1'b0};
    end
    if (cmd.start) begin
      tmo     <= prod[rbs_pkg::TMO_SHIFT +: rbs_pkg::TMO_W];
      rem     <= '0;
      bit_cnt <= '0;
    end else if (cmd.step) begin
      rem     <= (trial >= half) ? trial - half : trial;
      bit_cnt <= bit_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data.attempt_number     <= count;
      out_data.scheduled          <= (entry != '0);
      out_data.select_next_server <= (entry == '0);
      out_data.delay_ms           <= (entry != '0) ? half + rem : '0;
      out_data.timeout_s          <= (entry != '0) ? tmo : '0;
    end
  end

  `RBS_ASSERT_IMP(a_rem_bound, cmd.step, rem < half)
  `RBS_ASSERT_IMP(a_finish_free, cmd.finish, out_free)

endmodule

// ===== rtl/retry_backoff_scheduler_top.sv =====
// Top level of the retry backoff scheduler.
// An accepted request passes through lookup, a 32-step bit-serial jitter remainder
// and a done state that holds until the output register is free; lookup goes
// straight to done when the entry is zero or one ms. One item is in flight at a time.
// The output register lets the next word be accepted while a result waits.
// Synchronous reset restores the default timeout table and clears both retry counters.
module retry_backoff_scheduler_top #(
  parameter int TABLE_ENTRIES = rbs_pkg::DEFAULT_TABLE_ENTRIES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rbs_pkg::ADDR_W-1:0] paddr,
  input  logic [rbs_pkg::DATA_W-1:0] pwdata,
  output logic [rbs_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  rbs_pkg::req_t              in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output rbs_pkg::rsp_t              out_data
);

  rbs_pkg::slot_table_t slots;
  rbs_pkg::cmd_t        cmd;
  rbs_pkg::status_t     status;

  rbs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .slots   (slots)
  );

  rbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rbs_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .slots     (slots),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
